@@ rtl/core/mros_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath structs for the offload selector
package mros_pkg;

    localparam int MAX_RANKS = 64;
    localparam int RANK_W    = $clog2(MAX_RANKS);
    localparam int CNT_W     = RANK_W + 1;
    localparam int LOAD_W    = 31;
    localparam int REL_W     = 17;
    localparam int Q_SHIFT   = 16;
    localparam int PROD_W    = LOAD_W + REL_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]  RANK_COUNT_RESET    = CNT_W'(1);
    localparam logic [RANK_W-1:0] OWN_RANK_RESET      = '0;
    localparam logic [LOAD_W-1:0] ABS_THRESHOLD_RESET = LOAD_W'(2);
    localparam logic [REL_W-1:0]  REL_THRESHOLD_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANK_COUNT    = 2'd0,
        CFG_OWN_RANK      = 2'd1,
        CFG_ABS_THRESHOLD = 2'd2,
        CFG_REL_THRESHOLD = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        SWEEP_STATS  = 1'b0,
        SWEEP_SELECT = 1'b1
    } sweep_mode_t;

    typedef struct packed {
        logic        in_ready;
        logic        read_own;
        logic        capture_own;
        logic        sweep_start;
        logic        sweep_run;
        sweep_mode_t sweep_mode;
        logic        sel_init;
        logic        sel_advance;
        logic        mult_en;
        logic        mult_cur;
        logic        dec_fail;
        logic        dec_final;
        logic        out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic set_done;
        logic own_out;
        logic sweep_done;
        logic pass_global;
        logic found;
        logic pass_pair;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/core/mros_ifs.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for loads, results and configuration writes
interface mros_load_if;
    logic                        valid;
    logic                        ready;
    logic [mros_pkg::LOAD_W-1:0] load_value;

    modport source (output valid, output load_value, input ready);
    modport sink (input valid, input load_value, output ready);
endinterface

interface mros_result_if;
    logic                        valid;
    logic                        ready;
    logic                        offload;
    logic [mros_pkg::RANK_W-1:0] target_rank;

    modport source (output valid, output offload, output target_rank, input ready);
    modport sink (input valid, input offload, input target_rank, output ready);
endinterface

interface mros_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mros_pkg::CFG_IDX_W-1:0] index;
    logic [mros_pkg::LOAD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/mros_dp.sv @@
`timescale 1ns / 1ps
// datapath: config registers, load memory, sweep units, multiplier and result register
module mros_dp
(
    input  logic                clk,
    input  logic                rst_n,
    mros_load_if.sink           load_in,
    mros_result_if.source       result_out,
    mros_cfg_if.sink            cfg,
    input  mros_pkg::ctrl_cmd_t cmd,
    output mros_pkg::dp_status_t status
);

    logic [mros_pkg::CNT_W-1:0]  rank_count_reg;
    logic [mros_pkg::RANK_W-1:0] own_rank_reg;
    logic [mros_pkg::LOAD_W-1:0] abs_threshold_reg;
    logic [mros_pkg::REL_W-1:0]  rel_threshold_reg;
    logic [mros_pkg::CNT_W-1:0]  loaded_count_reg;

    logic [mros_pkg::LOAD_W-1:0] mem [mros_pkg::MAX_RANKS];
    logic [mros_pkg::LOAD_W-1:0] rd_data_reg;
    logic [mros_pkg::CNT_W-1:0]  rd_idx_reg;
    logic                        proc_valid_reg;
    logic [mros_pkg::RANK_W-1:0] proc_idx_reg;

    logic [mros_pkg::LOAD_W-1:0] cur_reg;
    logic [mros_pkg::LOAD_W-1:0] min_reg;
    logic [mros_pkg::LOAD_W-1:0] max_reg;
    logic [mros_pkg::RANK_W-1:0] pos_reg;

    logic [mros_pkg::RANK_W-1:0] other_pos_reg;
    logic [mros_pkg::RANK_W-1:0] step_reg;
    logic                        prev_valid_reg;
    logic [mros_pkg::LOAD_W-1:0] prev_val_reg;
    logic [mros_pkg::RANK_W-1:0] prev_idx_reg;
    logic                        best_valid_reg;
    logic [mros_pkg::LOAD_W-1:0] best_val_reg;
    logic [mros_pkg::RANK_W-1:0] best_idx_reg;

    logic [mros_pkg::PROD_W-1:0] product_reg;
    logic                        dec_off_reg;
    logic [mros_pkg::RANK_W-1:0] dec_tgt_reg;
    logic                        out_valid_reg;
    logic                        out_offload_reg;
    logic [mros_pkg::RANK_W-1:0] out_target_reg;

    logic [mros_pkg::CNT_W-1:0]  n_eff;
    logic [mros_pkg::CNT_W-1:0]  count_inc;
    logic                        in_fire;
    logic                        rd_issue;
    logic [mros_pkg::RANK_W-1:0] rd_addr;
    logic                        stats_proc;
    logic                        sel_proc;
    logic                        before_own;
    logic                        after_prev;
    logic                        take;
    logic [mros_pkg::LOAD_W-1:0] cur_minus_min;
    logic [mros_pkg::LOAD_W-1:0] span;
    logic [mros_pkg::LOAD_W-1:0] gap;
    logic                        span_rel_ok;
    logic [mros_pkg::LOAD_W-1:0] mult_op;

    always_comb
    begin
        if (rank_count_reg == '0)
        begin
            n_eff = mros_pkg::CNT_W'(1);
        end
        else if (rank_count_reg > mros_pkg::CNT_W'(mros_pkg::MAX_RANKS))
        begin
            n_eff = mros_pkg::CNT_W'(mros_pkg::MAX_RANKS);
        end
        else
        begin
            n_eff = rank_count_reg;
        end
    end

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_count_reg    <= mros_pkg::RANK_COUNT_RESET;
            own_rank_reg      <= mros_pkg::OWN_RANK_RESET;
            abs_threshold_reg <= mros_pkg::ABS_THRESHOLD_RESET;
            rel_threshold_reg <= mros_pkg::REL_THRESHOLD_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (mros_pkg::cfg_idx_t'(cfg.index))
                mros_pkg::CFG_RANK_COUNT:    rank_count_reg    <= cfg.data[mros_pkg::CNT_W-1:0];
                mros_pkg::CFG_OWN_RANK:      own_rank_reg      <= cfg.data[mros_pkg::RANK_W-1:0];
                mros_pkg::CFG_ABS_THRESHOLD: abs_threshold_reg <= cfg.data;
                mros_pkg::CFG_REL_THRESHOLD: rel_threshold_reg <= cfg.data[mros_pkg::REL_W-1:0];
            endcase
        end
    end

    // load capture
    assign load_in.ready   = cmd.in_ready;
    assign in_fire         = load_in.valid && cmd.in_ready;
    assign count_inc       = loaded_count_reg + mros_pkg::CNT_W'(1);
    assign status.set_done = in_fire && (count_inc >= n_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_count_reg <= '0;
        end
        else if (in_fire)
        begin
            loaded_count_reg <= status.set_done ? '0 : count_inc;
        end
    end

    // load memory, one write and one registered read port
    assign rd_issue = cmd.sweep_run && (rd_idx_reg < n_eff);
    assign rd_addr  = cmd.read_own ? own_rank_reg : rd_idx_reg[mros_pkg::RANK_W-1:0];

    always_ff @(posedge clk)
    begin
        if (in_fire && (loaded_count_reg < mros_pkg::CNT_W'(mros_pkg::MAX_RANKS)))
        begin
            mem[loaded_count_reg[mros_pkg::RANK_W-1:0]] <= load_in.load_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg     <= '0;
            proc_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_start)
            begin
                rd_idx_reg <= '0;
            end
            else if (rd_issue)
            begin
                rd_idx_reg <= rd_idx_reg + mros_pkg::CNT_W'(1);
            end
            proc_valid_reg <= rd_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= rd_idx_reg[mros_pkg::RANK_W-1:0];
    end

    assign status.sweep_done = proc_valid_reg
        && ({1'b0, proc_idx_reg} == (n_eff - mros_pkg::CNT_W'(1)));

    // statistics sweep: minimum, maximum and sorted position of own rank
    assign stats_proc = proc_valid_reg && (cmd.sweep_mode == mros_pkg::SWEEP_STATS);
    assign before_own = (proc_idx_reg != own_rank_reg)
        && ((rd_data_reg < cur_reg)
            || ((rd_data_reg == cur_reg) && (proc_idx_reg < own_rank_reg)));

    always_ff @(posedge clk)
    begin
        if (cmd.capture_own)
        begin
            cur_reg <= rd_data_reg;
        end
        if (stats_proc && ((proc_idx_reg == '0) || (rd_data_reg < min_reg)))
        begin
            min_reg <= rd_data_reg;
        end
        if (stats_proc && ((proc_idx_reg == '0) || (rd_data_reg > max_reg)))
        begin
            max_reg <= rd_data_reg;
        end
        if (cmd.sweep_start && (cmd.sweep_mode == mros_pkg::SWEEP_STATS))
        begin
            pos_reg <= '0;
        end
        else if (stats_proc && before_own)
        begin
            pos_reg <= pos_reg + mros_pkg::RANK_W'(1);
        end
    end

    // selection sweep: next rank in sorted order after the previous pick
    assign sel_proc   = proc_valid_reg && (cmd.sweep_mode == mros_pkg::SWEEP_SELECT);
    assign after_prev = !prev_valid_reg || (rd_data_reg > prev_val_reg)
        || ((rd_data_reg == prev_val_reg) && (proc_idx_reg > prev_idx_reg));
    assign take       = after_prev && (!best_valid_reg || (rd_data_reg < best_val_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sel_init)
            begin
                prev_valid_reg <= 1'b0;
            end
            else if (cmd.sel_advance)
            begin
                prev_valid_reg <= 1'b1;
            end
            if (cmd.sweep_start)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (sel_proc && take)
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sel_init)
        begin
            step_reg      <= '0;
            other_pos_reg <= mros_pkg::RANK_W'(n_eff - {1'b0, pos_reg} - mros_pkg::CNT_W'(1));
        end
        else if (cmd.sel_advance)
        begin
            step_reg     <= step_reg + mros_pkg::RANK_W'(1);
            prev_val_reg <= best_val_reg;
            prev_idx_reg <= best_idx_reg;
        end
        if (sel_proc && take)
        begin
            best_val_reg <= rd_data_reg;
            best_idx_reg <= proc_idx_reg;
        end
    end

    assign status.found = (step_reg == other_pos_reg);

    // shared threshold multiplier
    assign mult_op = cmd.mult_cur ? cur_reg : max_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mult_en)
        begin
            product_reg <= mros_pkg::PROD_W'(rel_threshold_reg) * mros_pkg::PROD_W'(mult_op);
        end
    end

    // threshold checks
    assign cur_minus_min = cur_reg - min_reg;
    assign span          = max_reg - min_reg;
    assign gap           = cur_reg - best_val_reg;
    assign span_rel_ok   = (max_reg == '0) ? (rel_threshold_reg == '0)
        : (mros_pkg::PROD_W'({span, {mros_pkg::Q_SHIFT{1'b0}}}) >= product_reg);

    assign status.own_out     = ({1'b0, own_rank_reg} >= n_eff);
    assign status.pass_global = (cur_minus_min >= abs_threshold_reg) && span_rel_ok
        && ({pos_reg, 1'b0} >= n_eff);
    assign status.pass_pair   = (best_val_reg < cur_reg) && (gap >= abs_threshold_reg)
        && (mros_pkg::PROD_W'({gap, {mros_pkg::Q_SHIFT{1'b0}}}) >= product_reg);

    // decision and output register
    always_ff @(posedge clk)
    begin
        if (cmd.dec_fail)
        begin
            dec_off_reg <= 1'b0;
            dec_tgt_reg <= '0;
        end
        else if (cmd.dec_final)
        begin
            dec_off_reg <= status.pass_pair;
            dec_tgt_reg <= status.pass_pair ? best_idx_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_offload_reg <= dec_off_reg;
            out_target_reg  <= dec_tgt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free        = !out_valid_reg || result_out.ready;
    assign result_out.valid       = out_valid_reg;
    assign result_out.offload     = out_offload_reg;
    assign result_out.target_rank = out_target_reg;

endmodule

@@ rtl/core/mros_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine sequencing capture, sweeps, checks and result hand-off
module mros_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mros_pkg::dp_status_t status,
    output mros_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [10:0] {
        ST_IDLE       = 11'b000_0000_0001,
        ST_START      = 11'b000_0000_0010,
        ST_OWN_WAIT   = 11'b000_0000_0100,
        ST_STATS      = 11'b000_0000_1000,
        ST_MULT_SPAN  = 11'b000_0001_0000,
        ST_CHECK_SPAN = 11'b000_0010_0000,
        ST_SEL_SWEEP  = 11'b000_0100_0000,
        ST_SEL_NEXT   = 11'b000_1000_0000,
        ST_MULT_PAIR  = 11'b001_0000_0000,
        ST_CHECK_PAIR = 11'b010_0000_0000,
        ST_RESULT     = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sweep_mode = mros_pkg::SWEEP_STATS;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.set_done)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.own_out)
                begin
                    cmd.dec_fail = 1'b1;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    cmd.read_own = 1'b1;
                    state_next   = ST_OWN_WAIT;
                end
            end
            ST_OWN_WAIT:
            begin
                cmd.capture_own = 1'b1;
                cmd.sweep_start = 1'b1;
                state_next      = ST_STATS;
            end
            ST_STATS:
            begin
                cmd.sweep_run = 1'b1;
                if (status.sweep_done)
                begin
                    state_next = ST_MULT_SPAN;
                end
            end
            ST_MULT_SPAN:
            begin
                cmd.mult_en = 1'b1;
                state_next  = ST_CHECK_SPAN;
            end
            ST_CHECK_SPAN:
            begin
                if (status.pass_global)
                begin
                    cmd.sel_init    = 1'b1;
                    cmd.sweep_start = 1'b1;
                    cmd.sweep_mode  = mros_pkg::SWEEP_SELECT;
                    state_next      = ST_SEL_SWEEP;
                end
                else
                begin
                    cmd.dec_fail = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_SEL_SWEEP:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_mode = mros_pkg::SWEEP_SELECT;
                if (status.sweep_done)
                begin
                    state_next = ST_SEL_NEXT;
                end
            end
            ST_SEL_NEXT:
            begin
                cmd.sweep_mode = mros_pkg::SWEEP_SELECT;
                if (status.found)
                begin
                    state_next = ST_MULT_PAIR;
                end
                else
                begin
                    cmd.sel_advance = 1'b1;
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_SEL_SWEEP;
                end
            end
            ST_MULT_PAIR:
            begin
                cmd.mult_en  = 1'b1;
                cmd.mult_cur = 1'b1;
                state_next   = ST_CHECK_PAIR;
            end
            ST_CHECK_PAIR:
            begin
                cmd.dec_final = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/mirror_rank_offload_selector_top.sv @@
`timescale 1ns / 1ps
// top level of the mirror rank offload selector
//
// load_in carries one rank load per transaction, ranks in index order. Loads
// that do not complete a set are accepted back to back and give no result. The
// transaction that brings the count up to rank_count starts one decision:
// the block reads its own rank, sweeps the load memory once for minimum,
// maximum and own sorted position, checks the thresholds through one shared
// multiplier, then finds the mirror rank by repeated selection sweeps, up to
// n/2 for n ranks; every sweep reads the ranks one by one through the single
// load memory read port. An out-of-range own_rank skips every step and a
// threshold reject skips the selection sweeps.
// result_out gives one transaction per decision from an output register;
// load_in stays ready while that result waits, until the next set completes.
// A stalled receiver holds the block in its final state with load_in not ready.
// cfg is always ready; index selects rank_count, own_rank, abs_threshold,
// rel_threshold, to be written only while no decision is in progress (the
// block does not enforce this). Reset restores the register defaults,
// clears the load count and the output; the load memory is not cleared.
module mirror_rank_offload_selector_top
(
    input  logic          clk,
    input  logic          rst_n,
    mros_load_if.sink     load_in,
    mros_result_if.source result_out,
    mros_cfg_if.sink      cfg
);

    mros_pkg::ctrl_cmd_t  cmd;
    mros_pkg::dp_status_t status;

    mros_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    mros_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_in    (load_in),
        .result_out (result_out),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

@@ rtl/core/mros_checker.sv @@
`timescale 1ns / 1ps
// port-level checker for the offload selector, bound to the top level
module mros_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        out_offload,
    input logic [mros_pkg::RANK_W-1:0] out_target
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_offload) && $stable(out_target))
        else $error("result changed while stalled");

    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_offload |-> out_target == '0)
        else $error("target rank nonzero without offload");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while loads were being taken");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind mirror_rank_offload_selector_top mros_checker u_mros_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (load_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .out_offload (result_out.offload),
    .out_target  (result_out.target_rank)
);
